// File: rtl/pnf_pkg.sv
// pnf_pkg: shared types and constants for the fractal noise block
// no dependencies
package pnf_pkg;
  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FREQ_BITS = 12;
  localparam int unsigned AMP_BITS = 16;
  localparam int unsigned MAX_OCT = 16;
  localparam logic [1:0] CFG_OCT = 2'd0;
  localparam logic [1:0] CFG_PERS = 2'd1;
  localparam logic [1:0] CFG_LAC = 2'd2;
endpackage

// File: rtl/pnf_mul.sv
// pnf_mul: shared signed 36x36 multiplier
// uses pnf_pkg
module pnf_mul import pnf_pkg::*; (
  input  logic signed [35:0] a_i,
  input  logic signed [35:0] b_i,
  output logic signed [71:0] p_o
);
  assign p_o = a_i * b_i;
endmodule

// File: rtl/perlin_noise_2d_fractal.sv
// perlin_noise_2d_fractal: top level, sequencer over one shared multiplier
// uses pnf_pkg and pnf_mul
//
// input channel: in_valid_i/in_stall_o carries kind, table index/value and the
// coordinates. a load transaction writes one permutation table entry and gives
// no result. an evaluate transaction runs the octave loop over a sequencer:
// each octave does ten dependent table reads, two fades, three lerps, the
// accumulate and the frequency/amplitude updates through the shared
// multiplier; after the last octave a restoring divider normalizes the sum.
// the block takes no new item until its result has been taken.
// output channel: out_valid_o/out_stall_i carries noise_value. while the
// receiver stalls the result holds and the block stays busy.
// config: cfg_valid_i/cfg_ready_o with cfg_index_i, cfg_data_i; written only
// while idle. reset sets octave_count 1, persistence 32768, lacunarity 8192.
// the table is undefined until loaded.
module perlin_noise_2d_fractal import pnf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] noise_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int TW = $clog2(TABLE_SIZE);
  localparam int S = FRAC_BITS + FREQ_BITS;
  localparam logic signed [35:0] ONE = 36'sd1 <<< FRAC_BITS;

  localparam logic [4:0] ST_IDLE = 5'd0, ST_SCX = 5'd1, ST_SCY = 5'd2, ST_R0 = 5'd3,
    ST_R1 = 5'd4, ST_R2 = 5'd5, ST_R3 = 5'd6, ST_R4 = 5'd7, ST_R5 = 5'd8,
    ST_F1 = 5'd9, ST_F2 = 5'd10, ST_F3 = 5'd11, ST_F4 = 5'd12, ST_L1 = 5'd13,
    ST_L2 = 5'd14, ST_L3 = 5'd15, ST_ACC = 5'd16, ST_AMP = 5'd17, ST_FRQ = 5'd18,
    ST_DIV = 5'd19, ST_OUT = 5'd20, ST_G = 5'd21;

  logic [4:0] st_q, st_d;
  logic [4:0] oct_cfg_q;
  logic [15:0] pers_q, lac_q;
  logic [7:0] perm_mem [TABLE_SIZE];
  logic [TW-1:0] raddr;
  logic [7:0] rdata_q;

  logic signed [31:0] x_q, y_q;
  logic [31:0] freq_q;
  logic [16:0] amp_q;
  logic [4:0] oct_q, oct_n_q;
  logic [2:0] sub_q;
  logic [TW-1:0] cx_q, cy_q, a_q, b_q;
  logic [7:0] h_q [4];
  logic signed [35:0] fx_q, fy_q, t_q, t2_q, t3_q, fu_q, fv_q, x1_q, x2_q, ga_q, gb_q;
  logic [51:0] total_q;
  logic [21:0] maxv_q;
  logic [67:0] rem_q;
  logic [67:0] den_q;
  logic [31:0] quo_q;
  logic [5:0] dcnt_q;
  logic [15:0] res_q;
  logic signed [35:0] ma, mb;
  logic signed [71:0] mp;

  pnf_mul u_mul (.a_i(ma), .b_i(mb), .p_o(mp));

  function automatic logic signed [35:0] grad(input logic [7:0] hh,
      input logic signed [35:0] gx, input logic signed [35:0] gy);
    logic signed [35:0] u, v;
    u = hh[2] ? gy : gx;
    v = hh[2] ? gx : gy;
    return (hh[0] ? -u : u) + (hh[1] ? -v : v);
  endfunction

  assign in_stall_o = st_q != ST_IDLE;
  assign cfg_ready_o = st_q == ST_IDLE;
  assign out_valid_o = st_q == ST_OUT;
  assign noise_value_o = res_q;

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (st_q)
      ST_SCX: begin ma = 36'(x_q); mb = $signed({4'd0, freq_q}); end
      ST_SCY: begin ma = 36'(y_q); mb = $signed({4'd0, freq_q}); end
      ST_F1: begin ma = t_q; mb = t_q; end
      ST_F2: begin ma = t2_q; mb = t_q; end
      ST_F3: begin ma = t3_q; mb = t2_q; end
      ST_L1: begin ma = fu_q; mb = gb_q - ga_q; end
      ST_L2: begin ma = fu_q; mb = gb_q - ga_q; end
      ST_L3: begin ma = fv_q; mb = x2_q - x1_q; end
      ST_ACC: begin ma = t_q; mb = 36'(amp_q); end
      ST_AMP: begin ma = 36'(amp_q); mb = 36'(pers_q); end
      ST_FRQ: begin ma = $signed({4'd0, freq_q}); mb = 36'(lac_q); end
      default: ;
    endcase
  end

  always_comb begin
    case (st_q)
      ST_R0: raddr = sub_q[0] ? cx_q + TW'(1) : cx_q;
      ST_R1: raddr = a_q + TW'(sub_q[0]);
      ST_R2: raddr = b_q + TW'(sub_q[0]);
      ST_R3: raddr = TW'(h_q[sub_q[1:0]]);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o && !kind_i) perm_mem[table_index_i[TW-1:0]] <= table_value_i;
    rdata_q <= perm_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      oct_cfg_q <= 5'd1;
      pers_q <= 16'd32768;
      lac_q <= 16'd8192;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_OCT: oct_cfg_q <= cfg_data_i[4:0];
          CFG_PERS: pers_q <= cfg_data_i;
          CFG_LAC: lac_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // sequencer; sub_q walks the reads of each pipelined memory step (two in ST_R0-ST_R2, four in ST_R3)
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_valid_i && kind_i) st_d = ST_SCX;
      ST_SCX: st_d = ST_SCY;
      ST_SCY: st_d = ST_R0;
      ST_R0: if (sub_q == 3'd2) st_d = ST_R1;
      ST_R1: if (sub_q == 3'd2) st_d = ST_R2;
      ST_R2: if (sub_q == 3'd2) st_d = ST_R3;
      ST_R3: if (sub_q == 3'd4) st_d = ST_F1;
      ST_F1: st_d = ST_F2;
      ST_F2: st_d = ST_F3;
      ST_F3: st_d = ST_F4;
      ST_F4: st_d = sub_q[0] ? ST_G : ST_F1;
      ST_G: st_d = ST_L1;
      ST_L1: st_d = ST_L2;
      ST_L2: st_d = ST_L3;
      ST_L3: st_d = ST_ACC;
      ST_ACC: st_d = ST_AMP;
      ST_AMP: st_d = ST_FRQ;
      ST_FRQ: st_d = (oct_q + 5'd1 == oct_n_q) ? ST_R4 : ST_SCX;
      ST_R4: st_d = ST_R5;
      ST_R5: st_d = ST_DIV;
      ST_DIV: if (dcnt_q == 6'd0) st_d = ST_OUT;
      ST_OUT: if (!out_stall_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    logic signed [71:0] g;
    logic signed [35:0] f, r;
    logic [67:0] trial;
    case (st_q)
      ST_IDLE: begin
        x_q <= coord_x_i;
        y_q <= coord_y_i;
        freq_q <= 32'd1 << FREQ_BITS;
        amp_q <= 17'd1 << AMP_BITS;
        total_q <= '0;
        maxv_q <= '0;
        oct_q <= '0;
        oct_n_q <= (oct_cfg_q == 5'd0) ? 5'd1 :
                   (oct_cfg_q > 5'(MAX_OCT)) ? 5'(MAX_OCT) : oct_cfg_q;
      end
      ST_SCX: begin
        cx_q <= mp[S+TW-1:S];
        fx_q <= 36'($unsigned(mp[S-1:FREQ_BITS]));
        sub_q <= '0;
      end
      ST_SCY: begin
        cy_q <= mp[S+TW-1:S];
        fy_q <= 36'($unsigned(mp[S-1:FREQ_BITS]));
        sub_q <= '0;
      end
      ST_R0, ST_R1, ST_R2: begin
        sub_q <= (sub_q == 3'd2) ? 3'd0 : sub_q + 3'd1;
        if (sub_q == 3'd1) begin
          if (st_q == ST_R0) a_q <= rdata_q[TW-1:0] + cy_q;
          else if (st_q == ST_R1) h_q[0] <= rdata_q;
          else h_q[2] <= rdata_q;
        end
        if (sub_q == 3'd2) begin
          if (st_q == ST_R0) b_q <= rdata_q[TW-1:0] + cy_q;
          else if (st_q == ST_R1) h_q[1] <= rdata_q;
          else h_q[3] <= rdata_q;
        end
      end
      ST_R3: begin
        sub_q <= (sub_q == 3'd4) ? 3'd0 : sub_q + 3'd1;
        if (sub_q == 3'd4) t_q <= fx_q;
      end
      ST_F1: begin t2_q <= 36'(mp >>> FRAC_BITS); end
      ST_F2: begin
        t3_q <= 36'(mp >>> FRAC_BITS);
        g = 72'(6) * t2_q - 72'(15) * t_q + 72'(10) * ONE;
        t2_q <= (g < 0) ? 36'sd0 : 36'(g);
      end
      ST_F3: begin
        g = mp >>> FRAC_BITS;
        f = (g > 72'(ONE)) ? ONE : 36'(g);
        if (sub_q[0]) fv_q <= f; else fu_q <= f;
      end
      ST_F4: begin
        sub_q <= sub_q + 3'd1;
        t_q <= fy_q;
      end
      ST_G: begin
        ga_q <= grad(h_q[0], fx_q, fy_q);
        gb_q <= grad(h_q[2], fx_q - ONE, fy_q);
      end
      ST_L1: begin
        x1_q <= ga_q + 36'(mp >>> FRAC_BITS);
        ga_q <= grad(h_q[1], fx_q, fy_q - ONE);
        gb_q <= grad(h_q[3], fx_q - ONE, fy_q - ONE);
      end
      ST_L2: x2_q <= ga_q + 36'(mp >>> FRAC_BITS);
      ST_L3: begin
        r = (x1_q + 36'(mp >>> FRAC_BITS) + ONE) >>> 1;
        r = (r < 0) ? 36'sd0 : (r > ONE) ? ONE : r;
        t_q <= r;
      end
      ST_ACC: begin
        total_q <= total_q + mp[51:0];
        maxv_q <= maxv_q + 22'(amp_q);
      end
      ST_AMP: amp_q <= mp[AMP_BITS+16:AMP_BITS];
      ST_FRQ: begin
        freq_q <= (mp[71:FREQ_BITS] > 60'hFFFFFFFF) ? 32'hFFFFFFFF : mp[FREQ_BITS+31:FREQ_BITS];
        oct_q <= oct_q + 5'd1;
      end
      ST_R4: begin
        rem_q <= 68'(total_q) << 16;
        den_q <= 68'(maxv_q) << (FRAC_BITS + 31);
        quo_q <= '0;
        dcnt_q <= 6'd32;
      end
      ST_R5: ;
      ST_DIV: begin
        if (dcnt_q != 6'd0) begin
          trial = rem_q - den_q;
          if (rem_q >= den_q) begin
            rem_q <= trial;
            quo_q <= {quo_q[30:0], 1'b1};
          end else quo_q <= {quo_q[30:0], 1'b0};
          den_q <= den_q >> 1;
          dcnt_q <= dcnt_q - 6'd1;
        end else res_q <= (quo_q > 32'hFFFF) ? 16'hFFFF : quo_q[15:0];
      end
      default: ;
    endcase
    // second-level reads: hash k is replaced by perm of hash k
    if (st_q == ST_R3 && sub_q != 3'd0 && sub_q <= 3'd4) h_q[sub_q[1:0] - 2'd1] <= rdata_q;
  end
endmodule

// File: rtl/pnf_checker.sv
// pnf_checker: port-level checks for the fractal noise block
// bound to perlin_noise_2d_fractal
module pnf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic cfg_ready_o,
  input logic [15:0] noise_value_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o)) else $error("hold");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("busy");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !out_valid_o) else $error("cfg");
endmodule

bind perlin_noise_2d_fractal pnf_checker u_chk (.*);
